@@ hdl/etb_pkg.sv @@
// ----------------------------------------------------------------------------
// Echo-acknowledged transmit ring buffer package
// Shared request and result types, operation codes and constants.
// ----------------------------------------------------------------------------
package etb_pkg;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_KICK  = 2'd1,
        FUNC_ECHO  = 2'd2,
        FUNC_TICK  = 2'd3
    } func_t;

    typedef struct packed {
        func_t      func;
        logic [7:0] byte_in;
    } req_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       status;
        logic       busy_res;
    } res_t;

    localparam logic [7:0] TIMEOUT_RESET = 8'd32;

endpackage

@@ hdl/etb_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module etb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/echo_acked_tx_ring_buffer_core.sv @@
// ----------------------------------------------------------------------------
// Echo-acknowledged transmit ring buffer core
// A write that fits completes from idle; kick, tick, a full write and echo
// go via the head state, and a matching echo with more data pending then
// runs wait and send; these states cover the registered byte store read.
// One request at a time; the result strobe cannot be stalled.
// Reset clears the pointers, the sending flag and the tick counter, and sets
// the timeout to 32; the byte store contents are undefined until written.
// ----------------------------------------------------------------------------
module echo_acked_tx_ring_buffer_core #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  etb_pkg::req_t req,
    output logic          done,
    output etb_pkg::res_t result,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_data
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_INDEX = AW'(BUFFER_DEPTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_HEAD = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_SEND = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] wi_reg, wi_next;
    logic [AW-1:0] ri_reg, ri_next;
    logic          sending_reg, sending_next;
    logic [7:0]    tick_reg, tick_next;
    logic [7:0]    timeout_reg;
    logic          done_reg, done_next;
    etb_pkg::res_t result_reg, result_next;
    etb_pkg::req_t req_reg, req_next;

    logic          wr_en;
    logic [7:0]    head;
    logic [AW-1:0] wi_inc, ri_inc;
    logic          pending, full;
    logic [7:0]    tick_inc;

    etb_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wi_reg),
        .wr_data (req.byte_in),
        .rd_addr (ri_reg),
        .rd_data (head)
    );

    assign wi_inc   = (wi_reg == LAST_INDEX) ? '0 : wi_reg + AW'(1);
    assign ri_inc   = (ri_reg == LAST_INDEX) ? '0 : ri_reg + AW'(1);
    assign pending  = (wi_reg != ri_reg);
    assign full     = (wi_inc == ri_reg);
    assign tick_inc = tick_reg + 8'd1;

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        wi_next      = wi_reg;
        ri_next      = ri_reg;
        sending_next = sending_reg;
        tick_next    = tick_reg;
        req_next     = req_reg;
        done_next    = 1'b0;
        result_next  = '0;
        wr_en        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    if (req.func == etb_pkg::FUNC_WRITE && !full)
                    begin
                        wr_en     = 1'b1;
                        wi_next   = wi_inc;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_HEAD;
                    end
                end
            end
            ST_HEAD:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                unique case (req_reg.func)
                    etb_pkg::FUNC_WRITE, etb_pkg::FUNC_KICK:
                    begin
                        result_next.status = (req_reg.func == etb_pkg::FUNC_WRITE);
                        if (!sending_reg && pending)
                        begin
                            sending_next         = 1'b1;
                            tick_next            = '0;
                            result_next.tx_valid = 1'b1;
                            result_next.tx_byte  = head;
                        end
                    end
                    etb_pkg::FUNC_ECHO:
                    begin
                        if (pending && head == req_reg.byte_in)
                        begin
                            ri_next = ri_inc;
                            if (wi_reg != ri_inc)
                            begin
                                state_next = ST_WAIT;
                                done_next  = 1'b0;
                            end
                            else
                            begin
                                sending_next = 1'b0;
                            end
                        end
                        else if (pending)
                        begin
                            tick_next            = '0;
                            result_next.tx_valid = 1'b1;
                            result_next.tx_byte  = head;
                        end
                        else
                        begin
                            sending_next = 1'b0;
                        end
                    end
                    etb_pkg::FUNC_TICK:
                    begin
                        if (tick_inc == timeout_reg)
                        begin
                            tick_next = '0;
                            if (!sending_reg && pending)
                            begin
                                sending_next         = 1'b1;
                                result_next.tx_valid = 1'b1;
                                result_next.tx_byte  = head;
                            end
                        end
                        else
                        begin
                            tick_next = tick_inc;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_WAIT:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                state_next           = ST_IDLE;
                done_next            = 1'b1;
                tick_next            = '0;
                result_next.tx_valid = 1'b1;
                result_next.tx_byte  = head;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        result_next.busy_res = sending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wi_reg      <= '0;
            ri_reg      <= '0;
            sending_reg <= 1'b0;
            tick_reg    <= '0;
            timeout_reg <= etb_pkg::TIMEOUT_RESET;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wi_reg      <= wi_next;
            ri_reg      <= ri_next;
            sending_reg <= sending_next;
            tick_reg    <= tick_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        result_reg <= result_next;
    end

endmodule
